// ===== design/pjs_pkg.sv =====
`default_nettype none
package pjs_pkg;

	localparam int NUM_JOBS  = 16;
	localparam int JOB_IDX_W = 4;
	localparam int TIME_W    = 16;
	localparam int PRIO_W    = 8;

	localparam logic MODE_SRT  = 1'b0;
	localparam logic MODE_PRIO = 1'b1;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef struct packed {
		logic                 valid;
		logic                 found;
		logic [JOB_IDX_W-1:0] idx;
		logic [TIME_W-1:0]    key;
		logic [TIME_W-1:0]    rem;
	} wave_t;

	typedef struct packed {
		logic                 load;
		logic                 run;
		logic [JOB_IDX_W-1:0] idx;
		logic [TIME_W-1:0]    arrival;
		logic [TIME_W-1:0]    burst;
		logic [PRIO_W-1:0]    prio;
	} upd_t;

endpackage
`default_nettype wire

// ===== design/pjs_cell.sv =====
`default_nettype none
module pjs_cell
	import pjs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [JOB_IDX_W-1:0] cell_idx,
	input  wire logic                 mode,
	input  wire logic [TIME_W-1:0]    now,
	input  wire upd_t                 upd,
	input  wire wave_t                wave_in,
	output wave_t                     wave_out,
	output logic                      present
);

	logic [TIME_W-1:0]    arrival_q;
	logic [TIME_W-1:0]    rem_q;
	logic [PRIO_W-1:0]    prio_q;
	logic                 present_q;
	logic                 pass_valid_q;
	logic                 pass_found_q;
	logic [JOB_IDX_W-1:0] pass_idx_q;
	logic [TIME_W-1:0]    pass_key_q;
	logic [TIME_W-1:0]    pass_rem_q;

	logic              ready;
	logic [TIME_W-1:0] key;
	logic              take;
	logic              hit;

	assign ready = present_q && (arrival_q <= now);
	assign key   = (mode == MODE_PRIO) ? {{(TIME_W-PRIO_W){1'b0}}, prio_q} : rem_q;
	assign take  = ready && (!wave_in.found || (key < wave_in.key));
	assign hit   = (upd.idx == cell_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q    <= 1'b0;
			pass_valid_q <= 1'b0;
		end else begin
			pass_valid_q <= wave_in.valid;
			if (upd.load && hit) begin
				present_q <= 1'b1;
			end else if (upd.run && hit && (rem_q <= TIME_W'(1))) begin
				present_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pass_found_q <= 1'b1;
			pass_idx_q   <= cell_idx;
			pass_key_q   <= key;
			pass_rem_q   <= rem_q;
		end else begin
			pass_found_q <= wave_in.found;
			pass_idx_q   <= wave_in.idx;
			pass_key_q   <= wave_in.key;
			pass_rem_q   <= wave_in.rem;
		end
		if (upd.load && hit) begin
			arrival_q <= upd.arrival;
			rem_q     <= upd.burst;
			prio_q    <= upd.prio;
		end else if (upd.run && hit) begin
			rem_q <= (rem_q <= TIME_W'(1)) ? '0 : rem_q - TIME_W'(1);
		end
	end

	assign wave_out.valid = pass_valid_q;
	assign wave_out.found = pass_found_q;
	assign wave_out.idx   = pass_idx_q;
	assign wave_out.key   = pass_key_q;
	assign wave_out.rem   = pass_rem_q;
	assign present        = present_q;

endmodule
`default_nettype wire

// ===== design/preemptive_job_scheduler.sv =====
`default_nettype none
// Channel    Valid      Stall      Transfer payload
// request    req_valid  req_stall  req_type job_index arrival_time burst_time priority_level
// response   rsp_valid  rsp_stall  running_job running_valid job_finished all_done time_now
// config     cfg_wr_en  -          cfg_wr_data (select_mode)
//
// A load passes the apply and done states before its result is registered; a tick
// first scans, as a selection wave walks the cell row one cell a cycle, then applies.
// One request is in work at a time; the result register frees the row for the
// next request while the result waits.
// Reset clears the present bits, the time counter, select_mode and all handshakes.
// A stalled result holds; a finished request waits until the result register frees.
module preemptive_job_scheduler
	import pjs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic                 cfg_wr_data,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire logic                 req_type,
	input  wire logic [JOB_IDX_W-1:0] job_index,
	input  wire logic [TIME_W-1:0]    arrival_time,
	input  wire logic [TIME_W-1:0]    burst_time,
	input  wire logic [PRIO_W-1:0]    priority_level,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output logic [JOB_IDX_W-1:0]      running_job,
	output logic                      running_valid,
	output logic                      job_finished,
	output logic                      all_done,
	output logic [TIME_W-1:0]         time_now
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]           state_q;
	logic                 mode_q;
	logic [TIME_W-1:0]    time_q;
	logic                 start_q;
	logic                 tick_q;
	logic [JOB_IDX_W-1:0] idx_q;
	logic [TIME_W-1:0]    arr_q;
	logic [TIME_W-1:0]    burst_q;
	logic [PRIO_W-1:0]    prio_q;
	logic [TIME_W-1:0]    now_q;
	logic                 found_q;
	logic [JOB_IDX_W-1:0] best_q;
	logic                 fin_q;
	logic                 rsp_valid_q;
	logic [JOB_IDX_W-1:0] running_job_q;
	logic                 running_valid_q;
	logic                 job_finished_q;
	logic                 all_done_q;
	logic [TIME_W-1:0]    time_now_q;

	wave_t                wave [NUM_JOBS+1];
	logic [NUM_JOBS-1:0]  present;
	logic [NUM_JOBS-1:0]  wave_valids;
	upd_t                 upd;
	logic                 accept;
	logic                 rsp_free;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	assign wave[0].valid = start_q;
	assign wave[0].found = 1'b0;
	assign wave[0].idx   = '0;
	assign wave[0].key   = '0;
	assign wave[0].rem   = '0;

	assign upd.load    = (state_q == ST_APPLY) && (tick_q == REQ_LOAD);
	assign upd.run     = (state_q == ST_APPLY) && (tick_q == REQ_TICK) && found_q;
	assign upd.idx     = (tick_q == REQ_TICK) ? best_q : idx_q;
	assign upd.arrival = arr_q;
	assign upd.burst   = burst_q;
	assign upd.prio    = prio_q;

	for (genvar i = 0; i < NUM_JOBS; i++) begin : g_cell
		pjs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (JOB_IDX_W'(i)),
			.mode     (mode_q),
			.now      (now_q),
			.upd      (upd),
			.wave_in  (wave[i]),
			.wave_out (wave[i+1]),
			.present  (present[i])
		);
		assign wave_valids[i] = wave[i+1].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_SRT;
			time_q      <= '0;
			start_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			start_q <= accept && (req_type == REQ_TICK);
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			if ((state_q == ST_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (req_type == REQ_TICK) ? ST_SCAN : ST_APPLY;
					end
				end
				ST_SCAN: begin
					if (wave[NUM_JOBS].valid) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (tick_q == REQ_TICK) begin
						time_q <= time_q + TIME_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_q  <= req_type;
			idx_q   <= job_index;
			arr_q   <= arrival_time;
			burst_q <= burst_time;
			prio_q  <= priority_level;
			now_q   <= time_q;
			found_q <= 1'b0;
		end
		if ((state_q == ST_SCAN) && wave[NUM_JOBS].valid) begin
			found_q <= wave[NUM_JOBS].found;
			best_q  <= wave[NUM_JOBS].idx;
			fin_q   <= (wave[NUM_JOBS].rem <= TIME_W'(1));
		end
		if ((state_q == ST_DONE) && rsp_free) begin
			running_job_q   <= found_q ? best_q : '0;
			running_valid_q <= found_q;
			job_finished_q  <= found_q && fin_q;
			all_done_q      <= ~|present;
			time_now_q      <= now_q;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign running_job   = running_job_q;
	assign running_valid = running_valid_q;
	assign job_finished  = job_finished_q;
	assign all_done      = all_done_q;
	assign time_now      = time_now_q;

	a_one_wave: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(wave_valids))
		else $error("more than one selection wave in the cell row");

	a_load_present: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && (tick_q == REQ_LOAD) |-> (|present))
		else $error("loaded entry not present");

	a_time_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) && (tick_q == REQ_TICK)
		|=> (time_q == TIME_W'($past(time_q) + 1'b1)))
		else $error("time did not advance by one on a tick");

	a_time_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_APPLY) |=> $stable(time_q))
		else $error("time changed outside a tick update");

	a_fin_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (running_valid || !job_finished))
		else $error("job finished without running");

endmodule
`default_nettype wire

// ===== verif/preemptive_job_scheduler_tb.sv =====
module preemptive_job_scheduler_tb;
	import pjs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 16;
	localparam int PHASE_ITEMS = 100;
	localparam int DRAIN_WAIT  = 2 * (NUM_JOBS + 4);

	typedef struct packed {
		logic [JOB_IDX_W-1:0] job;
		logic                 ran;
		logic                 finished;
		logic                 drained;
		logic [TIME_W-1:0]    stamp;
	} sched_rsp_t;

	class job_table_tracker;
		logic [TIME_W-1:0] arrival [NUM_JOBS];
		logic [TIME_W-1:0] remaining [NUM_JOBS];
		logic [PRIO_W-1:0] prio [NUM_JOBS];
		bit                present [NUM_JOBS];
		logic [TIME_W-1:0] clock_now;
		logic              mode;
		sched_rsp_t        pending_results [$];
		int                mismatches;

		function new();
			clock_now = '0;
			mode = MODE_SRT;
			mismatches = 0;
			foreach (present[i]) present[i] = 1'b0;
		endfunction

		function void note_request(input logic typ, input logic [JOB_IDX_W-1:0] idx,
				input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] burst,
				input logic [PRIO_W-1:0] pr);
			sched_rsp_t        r;
			int                best;
			bit                found;
			logic [TIME_W-1:0] key;
			logic [TIME_W-1:0] best_key;
			r = '0;
			r.stamp = clock_now;
			best = 0;
			found = 1'b0;
			best_key = '0;
			if (typ == REQ_LOAD) begin
				arrival[idx] = arr;
				remaining[idx] = burst;
				prio[idx] = pr;
				present[idx] = 1'b1;
			end else begin
				for (int i = 0; i < NUM_JOBS; i++) begin
					if (present[i] && arrival[i] <= clock_now) begin
						key = (mode == MODE_PRIO) ? TIME_W'(prio[i]) : remaining[i];
						if (!found || key < best_key) begin
							found = 1'b1;
							best = i;
							best_key = key;
						end
					end
				end
				if (found) begin
					r.ran = 1'b1;
					r.job = JOB_IDX_W'(best);
					if (remaining[best] <= TIME_W'(1)) begin
						remaining[best] = '0;
						present[best] = 1'b0;
						r.finished = 1'b1;
					end else begin
						remaining[best] = remaining[best] - TIME_W'(1);
					end
				end
				clock_now = clock_now + TIME_W'(1);
			end
			r.drained = 1'b1;
			foreach (present[i]) if (present[i]) r.drained = 1'b0;
			pending_results.insert(pending_results.size(), r);
		endfunction

		task report_mismatch(input string what);
			mismatches++;
			$display("%0t: response mismatch: %s", $time, what);
		endtask

		task check_response(input sched_rsp_t got);
			sched_rsp_t want;
			if (pending_results.size() == 0) begin
				report_mismatch("response with no request outstanding");
			end else begin
				want = pending_results.pop_front();
				if (got.job !== want.job)
					report_mismatch($sformatf("running_job %0d, expected %0d",
						got.job, want.job));
				if (got.ran !== want.ran)
					report_mismatch($sformatf("running_valid %0b, expected %0b",
						got.ran, want.ran));
				if (got.finished !== want.finished)
					report_mismatch($sformatf("job_finished %0b, expected %0b",
						got.finished, want.finished));
				if (got.drained !== want.drained)
					report_mismatch($sformatf("all_done %0b, expected %0b",
						got.drained, want.drained));
				if (got.stamp !== want.stamp)
					report_mismatch($sformatf("time_now %0d, expected %0d",
						got.stamp, want.stamp));
			end
		endtask
	endclass

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 cfg_wr_en      = 1'b0;
	logic                 cfg_wr_data    = 1'b0;
	logic                 req_valid      = 1'b0;
	logic                 req_stall;
	logic                 req_type       = REQ_LOAD;
	logic [JOB_IDX_W-1:0] job_index      = '0;
	logic [TIME_W-1:0]    arrival_time   = '0;
	logic [TIME_W-1:0]    burst_time     = '0;
	logic [PRIO_W-1:0]    priority_level = '0;
	logic                 rsp_valid;
	logic                 rsp_stall      = 1'b0;
	logic [JOB_IDX_W-1:0] running_job;
	logic                 running_valid;
	logic                 job_finished;
	logic                 all_done;
	logic [TIME_W-1:0]    time_now;

	job_table_tracker sb;
	sched_rsp_t       observed;
	bit               pacing_on  = 1'b1;
	int               stall_left = 0;
	int               cycles     = 0;

	preemptive_job_scheduler dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req_type       (req_type),
		.job_index      (job_index),
		.arrival_time   (arrival_time),
		.burst_time     (burst_time),
		.priority_level (priority_level),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.running_job    (running_job),
		.running_valid  (running_valid),
		.job_finished   (job_finished),
		.all_done       (all_done),
		.time_now       (time_now)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("preemptive_job_scheduler verification failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else if (pacing_on && $urandom_range(0, 4) == 0) begin
			stall_left <= int'($urandom_range(0, 2));
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			observed.job = running_job;
			observed.ran = running_valid;
			observed.finished = job_finished;
			observed.drained = all_done;
			observed.stamp = time_now;
			sb.check_response(observed);
		end
	end

	task automatic send_request(input logic typ, input logic [JOB_IDX_W-1:0] idx,
			input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] burst,
			input logic [PRIO_W-1:0] pr);
		if (pacing_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_type <= typ;
		job_index <= idx;
		arrival_time <= arr;
		burst_time <= burst;
		priority_level <= pr;
		@(posedge clk);
		while (req_stall !== 1'b0) @(posedge clk);
		sb.note_request(typ, idx, arr, burst, pr);
		@(negedge clk);
	endtask

	task automatic tick_once();
		send_request(REQ_TICK, JOB_IDX_W'($urandom), TIME_W'($urandom),
			TIME_W'($urandom), PRIO_W'($urandom));
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic write_mode(input logic m);
		wait_drained();
		repeat (2) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.mode = m;
	endtask

	task automatic random_item();
		int                pick;
		logic [TIME_W-1:0] arr;
		logic [TIME_W-1:0] burst;
		logic [PRIO_W-1:0] pr;
		pick = int'($urandom_range(0, 99));
		if (pick < 22) begin
			pick = int'($urandom_range(0, 99));
			if (pick < 85)
				arr = sb.clock_now + TIME_W'($urandom_range(0, 12));
			else if (pick < 95)
				arr = TIME_W'($urandom);
			else
				arr = sb.clock_now - TIME_W'($urandom_range(0, 50));
			pick = int'($urandom_range(0, 99));
			if (pick < 80)
				burst = TIME_W'($urandom_range(1, 6));
			else if (pick < 95)
				burst = TIME_W'($urandom_range(7, 40));
			else
				burst = TIME_W'($urandom_range(1, 65535));
			if ($urandom_range(0, 1) == 0)
				pr = PRIO_W'($urandom);
			else
				pr = PRIO_W'($urandom_range(0, 3));
			send_request(REQ_LOAD, JOB_IDX_W'($urandom_range(0, NUM_JOBS - 1)), arr, burst, pr);
		end else begin
			tick_once();
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_mode(MODE_SRT);
		tick_once();
		send_request(REQ_LOAD, 4'd0, 16'd0, 16'd3, 8'd200);
		send_request(REQ_LOAD, 4'd15, 16'd0, 16'd3, 8'd0);
		send_request(REQ_LOAD, 4'd5, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_request(REQ_LOAD, 4'd7, 16'd0, 16'd0, 8'd0);
		repeat (8) tick_once();
		send_request(REQ_LOAD, 4'd5, 16'd0, 16'd1, 8'd0);
		tick_once();

		write_mode(MODE_PRIO);
		send_request(REQ_LOAD, 4'd3, 16'd0, 16'd2, 8'd9);
		send_request(REQ_LOAD, 4'd9, 16'd0, 16'd1, 8'd9);
		send_request(REQ_LOAD, 4'd12, sb.clock_now + 16'd2, 16'd1, 8'd0);
		repeat (5) tick_once();

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 0)
				write_mode(MODE_SRT);
			else if (phase == 1)
				write_mode(MODE_PRIO);
			else
				write_mode(($urandom_range(0, 1) == 0) ? MODE_SRT : MODE_PRIO);
			pacing_on = (phase < PHASES - 3);
			repeat (PHASE_ITEMS) random_item();
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(negedge clk);
		if (sb.mismatches == 0)
			$display("preemptive_job_scheduler verification clean");
		else
			$display("preemptive_job_scheduler verification failed");
		$finish;
	end

endmodule
